FILE: rtl/qdce_pkg.sv
package qdce_pkg;

    // item kinds
    typedef enum logic [1:0] {
        ACT_QUAD  = 2'd0,
        ACT_RAW   = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // widths of the packing path
    localparam int CodeW    = 35;   // longest quad code: 3 prefix bits + 4 x 8
    localparam int LenW     = 6;
    localparam int PendW    = 7;
    localparam int PendCntW = 3;
    localparam int AccW     = CodeW + PendW;
    localparam int BufW     = 40;   // five bytes at most per item
    localparam int ByteCntW = 3;

    // class prefixes, written msb first as they appear in the stream
    localparam logic [2:0] PFX_ZERO = 3'b011;
    localparam logic [1:0] PFX_W1   = 2'b11;
    localparam logic [1:0] PFX_W2   = 2'b10;
    localparam logic [1:0] PFX_W4   = 2'b00;
    localparam logic [2:0] PFX_W8   = 3'b010;

    // accepted item held in the input register
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  sample_a;
        logic [7:0]  sample_b;
        logic [7:0]  sample_c;
        logic [7:0]  sample_d;
        logic [31:0] raw_value;
        logic [5:0]  raw_count;
    } t_item;

    // code word, first bit in the lsb
    typedef struct packed {
        logic [CodeW-1:0] bits;
        logic [LenW-1:0]  len;
    } t_code;

endpackage

FILE: rtl/qdce_in_if.sv
interface qdce_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  sample_a;
    logic [7:0]  sample_b;
    logic [7:0]  sample_c;
    logic [7:0]  sample_d;
    logic [31:0] raw_value;
    logic [5:0]  raw_count;

    modport source (
        output valid, action, sample_a, sample_b, sample_c, sample_d, raw_value, raw_count,
        input  ready
    );
    modport sink (
        input  valid, action, sample_a, sample_b, sample_c, sample_d, raw_value, raw_count,
        output ready
    );
endinterface

FILE: rtl/qdce_out_if.sv
interface qdce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;

    modport source (
        output valid, out_byte, last_of_run, stream_end,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_run, stream_end,
        output ready
    );
endinterface

FILE: rtl/qdce_quad_coder.sv
module qdce_quad_coder (
    input  logic [7:0]     i_sample_a,
    input  logic [7:0]     i_sample_b,
    input  logic [7:0]     i_sample_c,
    input  logic [7:0]     i_sample_d,
    output qdce_pkg::t_code o_code
);

    logic [7:0] s [4];
    logic [7:0] d [4];
    logic [7:0] mn_ab, mn_cd, mx_ab, mx_cd, mn, mx;
    logic [8:0] sum;
    logic [7:0] mid;
    logic [3:0] fits_z, fits_1, fits_2, fits_4;

    assign s[0] = i_sample_a;
    assign s[1] = i_sample_b;
    assign s[2] = i_sample_c;
    assign s[3] = i_sample_d;

    // min / max tree and rounded midpoint
    always_comb begin
        mn_ab = (s[0] < s[1]) ? s[0] : s[1];
        mn_cd = (s[2] < s[3]) ? s[2] : s[3];
        mx_ab = (s[0] > s[1]) ? s[0] : s[1];
        mx_cd = (s[2] > s[3]) ? s[2] : s[3];
        mn    = (mn_ab < mn_cd) ? mn_ab : mn_cd;
        mx    = (mx_ab > mx_cd) ? mx_ab : mx_cd;
        sum   = {1'b0, mn} + {1'b0, mx} + 9'd1;
        mid   = sum[8:1];
    end

    // deltas modulo 256 and the range each one fits
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d[i]      = s[i] - mid;
            fits_z[i] = (d[i] == 8'h00);
            fits_1[i] = (d[i] == 8'h00) || (d[i] == 8'hFF);
            fits_2[i] = fits_1[i] || (d[i] == 8'hFE) || (d[i] == 8'h01);
            fits_4[i] = (d[i][7:3] == 5'h00) || (d[i][7:3] == 5'h1F);
        end
    end

    // smallest class holding all four; prefix bits go out msb first
    always_comb begin
        o_code.bits = '0;
        o_code.len  = '0;
        priority if (&fits_z) begin
            o_code.bits[2:0] = {qdce_pkg::PFX_ZERO[0], qdce_pkg::PFX_ZERO[1],
                                qdce_pkg::PFX_ZERO[2]};
            o_code.len       = 6'd3;
        end else if (&fits_1) begin
            o_code.bits[5:0] = {d[3][0], d[2][0], d[1][0], d[0][0],
                                qdce_pkg::PFX_W1[0], qdce_pkg::PFX_W1[1]};
            o_code.len       = 6'd6;
        end else if (&fits_2) begin
            o_code.bits[9:0] = {d[3][1:0], d[2][1:0], d[1][1:0], d[0][1:0],
                                qdce_pkg::PFX_W2[0], qdce_pkg::PFX_W2[1]};
            o_code.len       = 6'd10;
        end else if (&fits_4) begin
            o_code.bits[17:0] = {d[3][3:0], d[2][3:0], d[1][3:0], d[0][3:0],
                                 qdce_pkg::PFX_W4[0], qdce_pkg::PFX_W4[1]};
            o_code.len        = 6'd18;
        end else begin
            o_code.bits = {d[3], d[2], d[1], d[0],
                           qdce_pkg::PFX_W8[0], qdce_pkg::PFX_W8[1], qdce_pkg::PFX_W8[2]};
            o_code.len  = 6'd35;
        end
    end

endmodule

FILE: rtl/quad_delta_class_encoder.sv
// quad delta class encoder
//
// i_in (sink) takes one word per item: code a 2x2 quad, append 0..32 raw bits,
// or flush the partial byte. o_out (source) gives the packed stream one byte
// per word, first bit in the lsb; last_of_run marks the final byte an item
// caused and stream_end marks the padded byte of a flush.
// An accepted item sits in the input register, is coded and packed against
// the pending bits in a single pass, and its bytes are loaded into a five
// byte output buffer, from which its first byte shows on o_out. Items that
// complete no more than one byte flow at one per cycle while the receiver is
// ready; an item completing more holds the buffer until all its bytes (up to
// five for a quad) have drained at one byte per cycle while the receiver is ready.
// Items that complete no byte only update the pending bits and never wait on
// the buffer. When the receiver stalls the buffer holds, the input register
// fills, and i_in.ready drops until the item in it can move on.
// Reset (i_rst_n low at a clock edge) empties the input register and the
// buffer and clears the pending bits.
module quad_delta_class_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qdce_in_if.sink           i_in,
    qdce_out_if.source        o_out
);

    // input register
    logic                               r_in_valid;
    qdce_pkg::t_item                    r_in;
    // pending bits of an unfinished byte
    logic [qdce_pkg::PendW-1:0]         r_pend_bits, n_pend_bits;
    logic [qdce_pkg::PendCntW-1:0]      r_pend_cnt, n_pend_cnt;
    // output byte buffer
    logic [qdce_pkg::BufW-1:0]          r_buf;
    logic [qdce_pkg::ByteCntW-1:0]      r_cnt;
    logic                               r_flush;

    qdce_pkg::t_code                    quad_code;
    logic [qdce_pkg::CodeW-1:0]         code_bits;
    logic [qdce_pkg::LenW-1:0]          code_len;
    logic [5:0]                         raw_n;
    logic [32:0]                        raw_mask;
    logic [qdce_pkg::AccW-1:0]          acc, acc_rest;
    logic [qdce_pkg::LenW-1:0]          total;
    logic [qdce_pkg::ByteCntW-1:0]      n_bytes;
    logic [qdce_pkg::BufW-1:0]          n_buf;
    logic                               n_flush;
    logic                               out_take, buf_free, mv;
    qdce_pkg::t_action                  act;

    assign act = qdce_pkg::t_action'(r_in.action);

    qdce_quad_coder u_coder (
        .i_sample_a (r_in.sample_a),
        .i_sample_b (r_in.sample_b),
        .i_sample_c (r_in.sample_c),
        .i_sample_d (r_in.sample_d),
        .o_code     (quad_code)
    );

    // raw bits masked to the saturated count
    always_comb begin
        raw_n    = (r_in.raw_count > 6'd32) ? 6'd32 : r_in.raw_count;
        raw_mask = (33'd1 << raw_n) - 33'd1;
    end

    // code word of the held item
    always_comb begin
        unique case (act)
            qdce_pkg::ACT_QUAD: begin
                code_bits = quad_code.bits;
                code_len  = quad_code.len;
            end
            qdce_pkg::ACT_RAW: begin
                code_bits = {3'b000, r_in.raw_value & raw_mask[31:0]};
                code_len  = raw_n;
            end
            default: begin
                code_bits = '0;
                code_len  = '0;
            end
        endcase
    end

    // append to pending bits and split off whole bytes
    always_comb begin
        acc      = {{qdce_pkg::CodeW{1'b0}}, r_pend_bits}
                 | ({{qdce_pkg::PendW{1'b0}}, code_bits} << r_pend_cnt);
        total    = {3'b000, r_pend_cnt} + code_len;
        acc_rest = acc >> {total[5:3], 3'b000};
        n_buf    = acc[qdce_pkg::BufW-1:0];
        n_flush  = 1'b0;
        unique case (act)
            qdce_pkg::ACT_QUAD, qdce_pkg::ACT_RAW: begin
                n_bytes     = total[5:3];
                n_pend_bits = acc_rest[qdce_pkg::PendW-1:0];
                n_pend_cnt  = total[2:0];
            end
            qdce_pkg::ACT_FLUSH: begin
                n_bytes     = (r_pend_cnt != '0) ? 3'd1 : 3'd0;
                n_flush     = 1'b1;
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end
            default: begin
                n_bytes     = '0;
                n_pend_bits = r_pend_bits;
                n_pend_cnt  = r_pend_cnt;
            end
        endcase
    end

    // handshake between the stages
    assign out_take   = o_out.valid && o_out.ready;
    assign buf_free   = (r_cnt == '0) || ((r_cnt == 3'd1) && o_out.ready);
    assign mv         = r_in_valid && ((n_bytes == '0) || buf_free);
    assign i_in.ready = !r_in_valid || mv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (mv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action    <= i_in.action;
            r_in.sample_a  <= i_in.sample_a;
            r_in.sample_b  <= i_in.sample_b;
            r_in.sample_c  <= i_in.sample_c;
            r_in.sample_d  <= i_in.sample_d;
            r_in.raw_value <= i_in.raw_value;
            r_in.raw_count <= i_in.raw_count;
        end
    end

    // pending bits advance as each item is packed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (mv) begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    // output buffer: load whole bytes, drain one per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (mv && (n_bytes != '0)) begin
            r_cnt <= n_bytes;
        end else if (out_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv && (n_bytes != '0)) begin
            r_buf   <= n_flush ? {33'd0, r_pend_bits} : n_buf;
            r_flush <= n_flush;
        end else if (out_take) begin
            r_buf   <= {8'h00, r_buf[qdce_pkg::BufW-1:8]};
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = r_buf[7:0];
    assign o_out.last_of_run = (r_cnt == 3'd1);
    assign o_out.stream_end  = r_flush;

    // checks
    a_buf_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd5)
        else $error("byte buffer count above five");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stream_end) |-> o_out.last_of_run)
        else $error("flush byte not marked last");

    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mv |=> ($stable(r_pend_cnt) && $stable(r_pend_bits)))
        else $error("pending bits changed without an item");

    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv && (act == qdce_pkg::ACT_FLUSH)) |=> (r_pend_cnt == '0))
        else $error("flush left bits pending");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv && (n_bytes != '0)) |-> ((r_cnt == '0) || (r_cnt == 3'd1 && out_take)))
        else $error("byte buffer loaded while still holding bytes");

endmodule
